// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sketch core; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge out of reset.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle implication failed");
// Next-cycle implication, checked at every rising edge out of reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

// ----- src/wmh_pkg.sv -----
// ----------------------------------------------------------------------------
// wmh_pkg
// Types, widths and constants shared by the weighted MinHash sketch core.
// ----------------------------------------------------------------------------
package wmh_pkg;

    localparam int KeyW      = 64;
    localparam int WeightW   = 16;
    localparam int WordW     = 32;
    localparam int CountW    = 7;
    localparam int SlotOutW  = 6;
    localparam int CfgIdxW   = 8;
    localparam int CfgDataW  = 8;
    localparam int InDataW   = KeyW + WeightW;
    localparam int OutDataW  = 40;
    localparam int EntryW    = KeyW + WordW;

    localparam int ShiftA    = 21;
    localparam int ShiftB    = 35;
    localparam int ShiftC    = 4;

    localparam logic [KeyW-1:0]   BestMax          = {1'b0, {(KeyW-1){1'b1}}};
    localparam logic [CountW-1:0] HashCountReset   = 7'd64;
    localparam logic              UseWeightsReset  = 1'b1;

    localparam logic KIND_KEY   = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    localparam logic [CfgIdxW-1:0] CFG_HASH_COUNT  = 8'd0;
    localparam logic [CfgIdxW-1:0] CFG_USE_WEIGHTS = 8'd1;

    // One queued job: a flush or a key with its effective weight (never zero).
    typedef struct packed {
        logic               flush;
        logic [KeyW-1:0]    key;
        logic [WeightW-1:0] weight;
    } t_job;

    // Live configuration seen by the back end.
    typedef struct packed {
        logic [CountW-1:0] slot_count;
    } t_cfg;

    function automatic logic [KeyW-1:0] xorshift_step(input logic [KeyW-1:0] x);
        logic [KeyW-1:0] a;
        logic [KeyW-1:0] b;
        a = x ^ (x << ShiftA);
        b = a ^ (a >> ShiftB);
        return b ^ (b << ShiftC);
    endfunction

endpackage

// ----- src/wmh_ram.sv -----
// ----------------------------------------------------------------------------
// wmh_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wmh_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/wmh_front.sv -----
// ----------------------------------------------------------------------------
// wmh_front
// Configuration registers and input classification; pushes jobs to the queue.
// ----------------------------------------------------------------------------
module wmh_front #(
    parameter int MAX_SLOTS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [wmh_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [wmh_pkg::CfgDataW-1:0]   i_cfg_data,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [wmh_pkg::InDataW-1:0]    i_s_axis_tdata,
    input  logic                           i_s_axis_tuser,
    input  logic                           i_q_full,
    output logic                           o_q_push,
    output wmh_pkg::t_job                  o_q_job,
    output wmh_pkg::t_cfg                  o_cfg
);
    import wmh_pkg::*;

    localparam logic [CountW-1:0] MaxSlotsC = CountW'(MAX_SLOTS);

    logic [CountW-1:0]  r_hash_count;
    logic               r_use_weights;
    logic [CountW-1:0]  w_slots;
    logic [WeightW-1:0] w_weight;
    logic               w_flush;
    logic               w_skip;

    // Take nothing while reset is held.
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_count  <= HashCountReset;
            r_use_weights <= UseWeightsReset;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HASH_COUNT:  r_hash_count  <= i_cfg_data[CountW-1:0];
                CFG_USE_WEIGHTS: r_use_weights <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Clamp the slot count to the storage depth.
    assign w_slots  = (r_hash_count > MaxSlotsC) ? MaxSlotsC : r_hash_count;
    assign w_flush  = (i_s_axis_tuser == KIND_FLUSH);
    assign w_weight = r_use_weights ? i_s_axis_tdata[InDataW-1:KeyW] : WeightW'(1);
    // Drop keys that would touch nothing.
    assign w_skip   = !w_flush && ((w_weight == '0) || (w_slots == '0));

    assign o_s_axis_tready   = i_rst_n && !i_q_full;
    assign o_q_push          = i_s_axis_tvalid && o_s_axis_tready && !w_skip;
    assign o_q_job.flush     = w_flush;
    assign o_q_job.key       = i_s_axis_tdata[KeyW-1:0];
    assign o_q_job.weight    = w_weight;
    assign o_cfg.slot_count  = w_slots;

endmodule

// ----- src/wmh_queue.sv -----
// ----------------------------------------------------------------------------
// wmh_queue
// Two-entry job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module wmh_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wmh_pkg::t_job i_push_job,
    output logic          o_full,
    input  logic          i_pop,
    output wmh_pkg::t_job o_pop_job,
    output logic          o_empty
);
    import wmh_pkg::*;

    t_job       r_slot [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_full    = (r_count == 2'd2);
    assign o_empty   = (r_count == 2'd0);
    assign w_push    = i_push && !o_full;
    assign w_pop     = i_pop && !o_empty;
    assign o_pop_job = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- src/wmh_back.sv -----
// ----------------------------------------------------------------------------
// wmh_back
// Runs the xorshift chain across the slots for key jobs; emits and clears on
// flush jobs. Owns the slot RAM, the slot valid bits and the output register.
// ----------------------------------------------------------------------------
module wmh_back #(
    parameter int MAX_SLOTS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  wmh_pkg::t_cfg                   i_cfg,
    input  logic                            i_q_empty,
    input  wmh_pkg::t_job                   i_q_job,
    output logic                            o_q_pop,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [wmh_pkg::OutDataW-1:0]    o_m_axis_tdata,
    output logic                            o_m_axis_tlast
);
    import wmh_pkg::*;

    localparam int SlotW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_FETCH,
        S_STEP,
        S_FL_WAIT,
        S_FL_OUT
    } t_state;

    t_state             r_state;
    logic [KeyW-1:0]    r_key;
    logic [WeightW-1:0] r_weight;
    logic [WeightW-1:0] r_cnt;
    logic [SlotW-1:0]   r_addr;
    logic [KeyW-1:0]    r_x;
    logic [KeyW-1:0]    r_best;
    logic               r_dirty;
    logic [MAX_SLOTS-1:0] r_valid;
    logic               r_o_valid;
    logic [SlotOutW-1:0] r_o_slot;
    logic [WordW-1:0]   r_o_word;
    logic               r_o_last;

    logic [KeyW-1:0]    n_x;
    logic               w_less;
    logic               w_last_step;
    logic               w_at_last;
    logic               w_fl_last;
    logic               w_out_free;
    logic               w_o_load;
    logic [CountW-1:0]  w_slot_ext;
    logic [WordW-1:0]   w_half;
    logic               w_we;
    logic [EntryW-1:0]  w_wdata;
    logic [EntryW-1:0]  w_rdata;
    logic [KeyW-1:0]    w_rd_best;
    logic [WordW-1:0]   w_rd_word;

    wmh_ram #(
        .WIDTH (EntryW),
        .DEPTH (MAX_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_addr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // Unwritten slots read as their cleared values.
    assign w_rd_best = r_valid[r_addr] ? w_rdata[EntryW-1:WordW] : BestMax;
    assign w_rd_word = r_valid[r_addr] ? w_rdata[WordW-1:0] : '0;

    assign n_x         = xorshift_step(r_x);
    assign w_less      = $signed(n_x) < $signed(r_best);
    assign w_last_step = (r_cnt == WeightW'(1));
    assign w_slot_ext  = CountW'(r_addr);
    assign w_at_last   = (w_slot_ext == (i_cfg.slot_count - CountW'(1)));
    assign w_fl_last   = (i_cfg.slot_count == '0) || w_at_last;
    assign w_half      = r_addr[0] ? r_key[KeyW-1:WordW] : r_key[WordW-1:0];
    assign w_out_free  = !r_o_valid || i_m_axis_tready;
    assign w_o_load    = (r_state == S_FL_OUT) && w_out_free;

    // Write back the slot at its last step if anything improved.
    assign w_we    = (r_state == S_STEP) && w_last_step && (r_dirty || w_less);
    assign w_wdata = {(w_less ? n_x : r_best), w_half};

    assign o_q_pop = (r_state == S_IDLE) && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_o_load) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_key    <= i_q_job.key;
                        r_weight <= i_q_job.weight;
                        r_x      <= i_q_job.key;
                        r_addr   <= '0;
                        r_state  <= i_q_job.flush ? S_FL_WAIT : S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_state <= S_FETCH;
                end
                S_FETCH: begin
                    r_best  <= w_rd_best;
                    r_dirty <= 1'b0;
                    r_cnt   <= r_weight;
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    r_x   <= n_x;
                    r_cnt <= r_cnt - WeightW'(1);
                    if (w_less) begin
                        r_best  <= n_x;
                        r_dirty <= 1'b1;
                    end
                    if (w_last_step) begin
                        if (w_we) begin
                            r_valid[r_addr] <= 1'b1;
                        end
                        if (w_at_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_addr  <= r_addr + SlotW'(1);
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_FL_WAIT: begin
                    r_state <= S_FL_OUT;
                end
                S_FL_OUT: begin
                    if (w_out_free) begin
                        r_o_slot  <= SlotOutW'(r_addr);
                        r_o_word  <= w_rd_word;
                        r_o_last  <= w_fl_last;
                        if (w_fl_last) begin
                            r_valid <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_addr  <= r_addr + SlotW'(1);
                            r_state <= S_FL_WAIT;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {{(OutDataW - WordW - SlotOutW){1'b0}}, r_o_word, r_o_slot};
    assign o_m_axis_tlast  = r_o_last;

endmodule

// ----- src/weighted_minhash_sketch_core.sv -----
// ----------------------------------------------------------------------------
// weighted_minhash_sketch_core
// Weighted MinHash sketch over k-mer hash keys using xorshift64 chains.
// ----------------------------------------------------------------------------
// Feed one request per unique k-mer: tdata carries the signed 64-bit key and
// its 16-bit repeat count, tuser is the kind (0 key, 1 flush). For a key the
// core runs one xorshift64 (21, 35, 4) chain across the slots in use, stepping
// it repeat-count times per slot (once when weighting is off), and keeps the
// smallest signed value per slot together with the key's low half (even slot)
// or high half (odd slot). A flush streams out one result per slot in use
// (slot 0 alone when the slot count is zero), marks the final one with tlast,
// then clears the sketch. Keys with zero weight, or with no slots in use, are
// dropped at the input. Timing: the chain unit does one step per cycle, and
// each slot costs a registered RAM read ahead of its steps; a flush likewise
// needs its own RAM read for each emitted slot. A two-entry queue lets the
// input side keep taking requests while the back end works, until the queue
// fills, and the result register lets the back end move on while a result
// waits. No clearing pass is needed after reset: per-slot valid bits stand in
// for the cleared sketch. Write configuration only while the core is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module weighted_minhash_sketch_core #(
    parameter int MAX_SLOTS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [wmh_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [wmh_pkg::CfgDataW-1:0]   i_cfg_data,
    // input stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [wmh_pkg::InDataW-1:0]    i_s_axis_tdata,   // kmer_key[63:0], repeat_count[79:64]
    input  logic                           i_s_axis_tuser,   // kind
    // result stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [wmh_pkg::OutDataW-1:0]   o_m_axis_tdata,   // slot_index[5:0], sketch_word[37:6], zero pad
    output logic                           o_m_axis_tlast    // last
);
    import wmh_pkg::*;

    logic q_push;
    t_job q_push_job;
    logic q_full;
    logic q_pop;
    t_job q_pop_job;
    logic q_empty;
    t_cfg cfg;

    // Front end: config registers, classify and drop, push jobs.
    wmh_front #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_job         (q_push_job),
        .o_cfg           (cfg)
    );

    // Decouple input acceptance from chain execution.
    wmh_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_job (q_push_job),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_pop_job  (q_pop_job),
        .o_empty    (q_empty)
    );

    // Back end: chain steps, slot updates, flush emission.
    wmh_back #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_q_empty       (q_empty),
        .i_q_job         (q_pop_job),
        .o_q_pop         (q_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // Hold off the input while the queue is full.
    `ASSERT_IMPLY(a_full_stalls_input, i_clk, i_rst_n, q_full, !o_s_axis_tready)
    // Slots of a flush run come out in ascending order.
    `ASSERT_NEXT(a_slot_order, i_clk, i_rst_n, o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast, !o_m_axis_tvalid || (o_m_axis_tdata[5:0] == $past(o_m_axis_tdata[5:0]) + 6'd1))
    // A new run always opens at slot zero.
    `ASSERT_NEXT(a_run_restart, i_clk, i_rst_n, o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast, !o_m_axis_tvalid || (o_m_axis_tdata[5:0] == 6'd0))

endmodule
